/* sv/ufd_pkg.sv */
package ufd_pkg;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_TAIL = 2'd1;
  localparam logic [1:0] ST_CRC  = 2'd2;

  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  localparam logic [7:0]  HEAD_RESET  = 8'hAA;
  localparam logic [7:0]  TAIL_RESET  = 8'h55;
  localparam logic [7:0]  MIN_LEN     = 8'd3;
  localparam logic [7:0]  CRC_MIN_LEN = 8'd6;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } ufd_wr_t;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic [7:0] length;
    logic [7:0] ftype;
  } ufd_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* sv/ufd_ram.sv */
module ufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ufd_parser.sv */
module ufd_parser #(
  parameter int MAX_FRAME_BYTES = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_en,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          head_byte,
  input  logic [7:0]          tail_byte,
  output ufd_pkg::ufd_wr_t     wr,
  output ufd_pkg::ufd_result_t res
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES);

  ufd_pkg::phase_t phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  type_byte, type_byte_next;

  logic [8:0] pos9, len9;
  logic [7:0] pos_inc;

  assign pos9    = {1'b0, byte_position};
  assign len9    = {1'b0, expected_length};
  assign pos_inc = byte_position + 8'd1;

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    expected_length_next = expected_length;
    running_crc_next     = running_crc;
    received_crc_next    = received_crc;
    type_byte_next       = type_byte;
    wr                   = '{en: 1'b0, addr: byte_position, data: rx_byte};
    res                  = '{done: 1'b0, status: ufd_pkg::ST_GOOD,
                             length: expected_length, ftype: type_byte};
    if (rx_en) begin
      unique case (phase)
        ufd_pkg::PH_IDLE: begin
          if (rx_byte == head_byte) begin
            wr.en                = 1'b1;
            wr.addr              = 8'd0;
            byte_position_next   = 8'd1;
            expected_length_next = 8'd0;
            running_crc_next     = 16'd0;
            received_crc_next    = 16'd0;
            phase_next           = ufd_pkg::PH_LEN;
          end
        end
        ufd_pkg::PH_LEN: begin
          wr.en = 1'b1;
          if (rx_byte < ufd_pkg::MIN_LEN || rx_byte > MAX_LEN) begin
            phase_next           = ufd_pkg::PH_IDLE;
            byte_position_next   = 8'd0;
            expected_length_next = 8'd0;
          end else begin
            expected_length_next = rx_byte;
            byte_position_next   = pos_inc;
            phase_next           = ufd_pkg::PH_BODY;
          end
        end
        ufd_pkg::PH_BODY: begin
          wr.en = 1'b1;
          if (byte_position == 8'd2) begin
            type_byte_next = rx_byte;
          end
          if (byte_position >= 8'd3 && (pos9 + 9'd3) < len9) begin
            running_crc_next = ufd_pkg::crc16_byte(running_crc, rx_byte);
          end
          if ((pos9 + 9'd3) == len9) begin
            received_crc_next[7:0] = rx_byte;
          end
          if ((pos9 + 9'd2) == len9) begin
            received_crc_next[15:8] = rx_byte;
          end
          byte_position_next = pos_inc;
          if (pos_inc >= expected_length) begin
            res.done  = 1'b1;
            res.ftype = type_byte_next;
            if (rx_byte != tail_byte) begin
              res.status = ufd_pkg::ST_TAIL;
            end else if (expected_length < ufd_pkg::CRC_MIN_LEN ||
                         running_crc != received_crc) begin
              res.status = ufd_pkg::ST_CRC;
            end else begin
              res.status = ufd_pkg::ST_GOOD;
            end
            phase_next           = ufd_pkg::PH_IDLE;
            byte_position_next   = 8'd0;
            expected_length_next = 8'd0;
          end
        end
        default: begin
          phase_next           = ufd_pkg::PH_IDLE;
          byte_position_next   = 8'd0;
          expected_length_next = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ufd_pkg::PH_IDLE;
      byte_position   <= 8'd0;
      expected_length <= 8'd0;
      running_crc     <= 16'd0;
      received_crc    <= 16'd0;
      type_byte       <= 8'd0;
    end else begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      expected_length <= expected_length_next;
      running_crc     <= running_crc_next;
      received_crc    <= received_crc_next;
      type_byte       <= type_byte_next;
    end
  end

endmodule

/* sv/uart_frame_deframer_crc16.sv */
// channel  dir  transaction                 tdata (low bit up)                     tuser
// s_axis   in   byte or store read          rx_byte, read_index, pad               cmd
// m_axis   out  frame report or read reply  frame_status, frame_length,            result_kind
//                                           frame_type, read_byte, pad
// cfg      in   register write              cfg_data                               -
//
// one transaction per cycle in and out unless the output stalls; results pass through stage one and the output register
// parser state updates in the accept cycle; frame store written or read there too
// store read data arrives in the next cycle from the synchronous ram port
// rst is synchronous, active high; no clearing pass, the store starts undefined
// a stalled output holds the pending result
// s_axis_tready drops while both stages hold results and m_axis_tready is low
module uart_frame_deframer_crc16 #(
  parameter int MAX_FRAME_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], read_index[14:8], zero[15]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // frame_status[1:0], frame_length[9:2],
                                      // frame_type[17:10], read_byte[25:18], zero[31:26]
  output logic        m_axis_tuser,   // result_kind
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int         AW      = $clog2(MAX_FRAME_BYTES);
  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES);

  logic [7:0] head_byte, tail_byte;

  logic       accept;
  logic       rx_en;
  logic       rd_en;
  logic [7:0] ridx_ext;
  logic [7:0] ram_rdata;

  ufd_pkg::ufd_wr_t     wr;
  ufd_pkg::ufd_result_t res;

  logic       s1_valid, s1_kind, s1_inrange, s1_adv;
  logic [1:0] s1_status;
  logic [7:0] s1_len, s1_type;

  logic [1:0] m_status;
  logic [7:0] m_len, m_type, m_read_byte;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign rx_en    = accept && (s_axis_tuser == ufd_pkg::CMD_RX);
  assign rd_en    = accept && (s_axis_tuser == ufd_pkg::CMD_READ);
  assign ridx_ext = {1'b0, s_axis_tdata[14:8]};

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= ufd_pkg::HEAD_RESET;
      tail_byte <= ufd_pkg::TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ufd_pkg::REG_HEAD: head_byte <= cfg_data;
        ufd_pkg::REG_TAIL: tail_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  ufd_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .rx_en    (rx_en),
    .rx_byte  (s_axis_tdata[7:0]),
    .head_byte(head_byte),
    .tail_byte(tail_byte),
    .wr       (wr),
    .res      (res)
  );

  ufd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr[AW-1:0]),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(ridx_ext[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en || res.done) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_kind    <= ufd_pkg::KIND_READ;
      s1_status  <= ufd_pkg::ST_GOOD;
      s1_len     <= 8'd0;
      s1_type    <= 8'd0;
      s1_inrange <= ridx_ext < MAX_LEN;
    end else if (res.done) begin
      s1_kind    <= ufd_pkg::KIND_REPORT;
      s1_status  <= res.status;
      s1_len     <= res.length;
      s1_type    <= res.ftype;
      s1_inrange <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tuser <= s1_kind;
      m_status     <= s1_status;
      m_len        <= s1_len;
      m_type       <= s1_type;
      m_read_byte  <= (s1_kind == ufd_pkg::KIND_READ && s1_inrange) ? ram_rdata : 8'd0;
    end
  end

  assign m_axis_tdata = {6'd0, m_read_byte, m_type, m_len, m_status};

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("pending result lost from stage one");

  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (!s1_valid || s1_adv))
    else $error("store read issued while stage one is blocked");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && (wr.en || res.done)))
    else $error("read and parser activity in the same cycle");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.addr < MAX_LEN))
    else $error("frame store write beyond its depth");
`endif

endmodule
